/* rtl/aisp_pkg.sv */
// ----------------------------------------------------------------------------
// aisp_pkg
// Shared types and constants for the image stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package aisp_pkg;

    localparam int BYTE_W     = 8;
    localparam int MODE_W     = 2;
    localparam int POS_W      = 9;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int FILL_W     = 8;
    localparam int FIELD_W    = 2;
    localparam int WIN_W      = 56;
    localparam int ACC_EXT_W  = 12;

    localparam logic [CFG_W-1:0] LINE_BYTES_RST  = 10'd264;
    localparam logic [CFG_W-1:0] FRAME_LINES_RST = 10'd162;
    localparam logic [CFG_W-1:0] LINE_BYTES_MIN  = 10'd2;
    localparam logic [CFG_W-1:0] LINE_BYTES_MAX  = 10'd512;
    localparam logic [CFG_W-1:0] FRAME_LINES_MIN = 10'd1;
    localparam logic [CFG_W-1:0] FRAME_LINES_MAX = 10'd512;

    // text line ends after this many bytes
    localparam logic [FILL_W-1:0] FILL_MAX      = 8'd255;
    localparam logic [FILL_W-1:0] FILL_IPD_MIN  = 8'd4;
    localparam logic [FILL_W-1:0] FILL_CONN_MIN = 8'd7;

    localparam logic [31:0]      PAT_IPD     = 32'h2B49_5044;
    localparam logic [WIN_W-1:0] PAT_CONNECT = 56'h43_4F4E_4E45_4354;

    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    localparam logic [FIELD_W-1:0] FIELD_CLIENT = 2'd1;
    localparam logic [FIELD_W-1:0] FIELD_MAX    = 2'd2;

    localparam logic [ACC_EXT_W-1:0] ACC_SAT = 12'd255;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SERVER = 2'd1,
        MODE_CLIENT = 2'd2,
        MODE_RECV   = 2'd3
    } t_link_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_BYTES  = 1'b0,
        CFG_FRAME_LINES = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic [MODE_W-1:0] link_mode;
        logic              pixel_valid;
        logic [BYTE_W-1:0] pixel_byte;
        logic [POS_W-1:0]  pixel_column;
        logic [POS_W-1:0]  pixel_line;
        logic              line_done;
        logic              frame_done;
        logic [BYTE_W-1:0] client_number;
        logic              connect_seen;
    } t_result;

endpackage

`default_nettype wire

/* rtl/aisp_rx_if.sv */
// ----------------------------------------------------------------------------
// aisp_rx_if
// Received byte channel: valid/ready with one byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface aisp_rx_if;
    logic                       valid;
    logic                       ready;
    logic [aisp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/aisp_res_if.sv */
// ----------------------------------------------------------------------------
// aisp_res_if
// Parser result channel: valid/ready with one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface aisp_res_if;
    logic                        valid;
    logic                        ready;
    logic [aisp_pkg::MODE_W-1:0] link_mode;
    logic                        pixel_valid;
    logic [aisp_pkg::BYTE_W-1:0] pixel_byte;
    logic [aisp_pkg::POS_W-1:0]  pixel_column;
    logic [aisp_pkg::POS_W-1:0]  pixel_line;
    logic                        line_done;
    logic                        frame_done;
    logic [aisp_pkg::BYTE_W-1:0] client_number;
    logic                        connect_seen;

    modport source (
        output valid, output link_mode, output pixel_valid, output pixel_byte,
        output pixel_column, output pixel_line, output line_done,
        output frame_done, output client_number, output connect_seen,
        input ready
    );
    modport sink (
        input valid, input link_mode, input pixel_valid, input pixel_byte,
        input pixel_column, input pixel_line, input line_done,
        input frame_done, input client_number, input connect_seen,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/aisp_out_skid.sv */
// ----------------------------------------------------------------------------
// aisp_out_skid
// Output register with one skid entry; drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module aisp_out_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire aisp_pkg::t_result i_data,
    output logic                   o_ready,
    aisp_res_if.source             o_res
);
    import aisp_pkg::*;

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    take;
    logic    push;

    assign o_ready = !r_skid_valid;
    assign take    = r_main_valid && o_res.ready;
    assign push    = i_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_main_valid <= push;
                end
            end else if (push) begin
                if (!r_main_valid) begin
                    r_main_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_skid_valid) begin
                r_main <= r_skid;
            end else begin
                r_main <= i_data;
            end
        end else if (push) begin
            if (!r_main_valid) begin
                r_main <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

    assign o_res.valid         = r_main_valid;
    assign o_res.link_mode     = r_main.link_mode;
    assign o_res.pixel_valid   = r_main.pixel_valid;
    assign o_res.pixel_byte    = r_main.pixel_byte;
    assign o_res.pixel_column  = r_main.pixel_column;
    assign o_res.pixel_line    = r_main.pixel_line;
    assign o_res.line_done     = r_main.line_done;
    assign o_res.frame_done    = r_main.frame_done;
    assign o_res.client_number = r_main.client_number;
    assign o_res.connect_seen  = r_main.connect_seen;

`ifndef NO_ASSERTIONS
    a_skid_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_main_valid)
        else $error("skid entry held without main entry");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_main_valid && !o_res.ready && i_valid))
        else $error("skid filled without a stalled main entry");

    a_skid_drains_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && o_res.ready) |=> (r_main == $past(r_skid)) && !r_skid_valid)
        else $error("skid entry not moved to main");
`endif

endmodule

`default_nettype wire

/* rtl/at_ipd_image_stream_parser.sv */
// ----------------------------------------------------------------------------
// at_ipd_image_stream_parser
// Receive-side parser for a Wi-Fi module link carrying camera frames.
// ----------------------------------------------------------------------------
// Takes one received byte per transaction and returns exactly one result per
// byte. The byte is parsed in the cycle it is accepted: the running state
// (byte window, header parser, text line fill, pixel column/line) updates at
// that edge and the result lands in an output register backed by one skid
// entry, so a byte can be accepted every cycle while the skid entry is free.
// The input stalls only when both output entries are full.
// line_bytes is used clamped to [2,512] and frame_lines to [1,512].
// Configuration writes take effect at the next byte.
`default_nettype none

module at_ipd_image_stream_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [aisp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [aisp_pkg::CFG_W-1:0]     i_cfg_data,
    aisp_rx_if.sink                            i_rx,
    aisp_res_if.source                         o_res
);
    import aisp_pkg::*;

    logic [CFG_W-1:0]   r_line_bytes;
    logic [CFG_W-1:0]   r_frame_lines;

    t_link_mode         r_mode,   n_mode;
    logic [WIN_W-1:0]   r_win,    n_win;
    logic               r_hdr,    n_hdr;
    logic [FIELD_W-1:0] r_field,  n_field;
    logic [BYTE_W-1:0]  r_acc,    n_acc;
    logic [BYTE_W-1:0]  r_client, n_client;
    logic [FILL_W-1:0]  r_fill,   n_fill;
    logic               r_cflag,  n_cflag;
    logic [POS_W-1:0]   r_col,    n_col;
    logic [POS_W-1:0]   r_line,   n_line;

    logic [CFG_W-1:0]     lb;
    logic [CFG_W-1:0]     fl;
    logic [CFG_W-1:0]     col_sum;
    logic [CFG_W-1:0]     line_sum;
    logic [ACC_EXT_W-1:0] acc_next;
    logic [BYTE_W-1:0]    b;
    logic                 accept;
    logic                 res_ready;
    t_result              res;

    assign b      = i_rx.rx_byte;
    assign accept = i_rx.valid && res_ready;
    assign i_rx.ready = res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes  <= LINE_BYTES_RST;
            r_frame_lines <= FRAME_LINES_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_LINE_BYTES:  r_line_bytes  <= i_cfg_data;
                CFG_FRAME_LINES: r_frame_lines <= i_cfg_data;
                default:         r_line_bytes  <= r_line_bytes;
            endcase
        end
    end

    always_comb begin
        lb = (r_line_bytes < LINE_BYTES_MIN) ? LINE_BYTES_MIN :
             (r_line_bytes > LINE_BYTES_MAX) ? LINE_BYTES_MAX : r_line_bytes;
        fl = (r_frame_lines < FRAME_LINES_MIN) ? FRAME_LINES_MIN :
             (r_frame_lines > FRAME_LINES_MAX) ? FRAME_LINES_MAX : r_frame_lines;
    end

    always_comb begin
        n_mode   = r_mode;
        n_hdr    = r_hdr;
        n_field  = r_field;
        n_acc    = r_acc;
        n_client = r_client;
        n_cflag  = r_cflag;
        n_col    = r_col;
        n_line   = r_line;
        n_win    = {r_win[WIN_W-BYTE_W-1:0], b};
        n_fill   = (r_fill < FILL_MAX) ? r_fill + 1'b1 : r_fill;
        col_sum  = {1'b0, r_col} + 1'b1;
        line_sum = {1'b0, r_line} + 1'b1;
        acc_next = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                 + {{(ACC_EXT_W-BYTE_W){1'b0}}, b - CH_ZERO};
        res      = '0;

        if (n_fill >= FILL_IPD_MIN && n_win[31:0] == PAT_IPD) begin
            n_hdr   = 1'b1;
            n_field = '0;
            n_acc   = '0;
            n_fill  = '0;
            n_cflag = 1'b0;
        end

        if (n_hdr) begin
            if (b == CH_COLON) begin
                n_client = n_acc;
                n_mode   = MODE_RECV;
                n_col    = '0;
                n_hdr    = 1'b0;
                n_fill   = '0;
                n_cflag  = 1'b0;
            end else if (b == CH_COMMA) begin
                if (n_field < FIELD_MAX) begin
                    n_field = n_field + 1'b1;
                end
            end else if (b >= CH_ZERO && b <= CH_NINE && n_field == FIELD_CLIENT) begin
                // digits only when entering from a running header use r_acc
                n_acc = (r_hdr && r_field == FIELD_CLIENT && acc_next <= ACC_SAT)
                      ? acc_next[BYTE_W-1:0] : ACC_SAT[BYTE_W-1:0];
            end
        end else begin
            if (n_fill >= FILL_CONN_MIN && n_win == PAT_CONNECT) begin
                n_cflag = 1'b1;
            end

            if (r_mode == MODE_RECV) begin
                res.pixel_valid  = 1'b1;
                res.pixel_byte   = b;
                res.pixel_column = r_col;
                res.pixel_line   = r_line;
                if (col_sum >= lb) begin
                    res.line_done = 1'b1;
                    n_col         = '0;
                    if (line_sum >= fl) begin
                        res.frame_done = 1'b1;
                        n_mode         = MODE_SERVER;
                        n_line         = '0;
                    end else begin
                        n_line = line_sum[POS_W-1:0];
                    end
                end else begin
                    n_col = col_sum[POS_W-1:0];
                end
            end

            if (b == CH_LF || n_fill >= FILL_MAX) begin
                if (n_cflag) begin
                    n_mode           = MODE_CLIENT;
                    res.connect_seen = 1'b1;
                end
                n_fill  = '0;
                n_cflag = 1'b0;
            end
        end

        res.link_mode     = n_mode;
        res.client_number = n_client;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_win    <= '0;
            r_hdr    <= 1'b0;
            r_field  <= '0;
            r_acc    <= '0;
            r_client <= '0;
            r_fill   <= '0;
            r_cflag  <= 1'b0;
            r_col    <= '0;
            r_line   <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_win    <= n_win;
            r_hdr    <= n_hdr;
            r_field  <= n_field;
            r_acc    <= n_acc;
            r_client <= n_client;
            r_fill   <= n_fill;
            r_cflag  <= n_cflag;
            r_col    <= n_col;
            r_line   <= n_line;
        end
    end

    aisp_out_skid u_out_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_data  (res),
        .o_ready (res_ready),
        .o_res   (o_res)
    );

`ifndef NO_ASSERTIONS
    a_pixel_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.pixel_valid) |->
            (o_res.pixel_byte == '0 && o_res.pixel_column == '0 && o_res.pixel_line == '0))
        else $error("pixel fields nonzero without pixel");

    a_frame_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_done) |-> (o_res.line_done && o_res.pixel_valid))
        else $error("frame done without line done");

    a_connect_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.connect_seen) |-> (o_res.link_mode == MODE_CLIENT))
        else $error("connect seen without client mode");

    a_frame_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_done && !o_res.connect_seen) |->
            (o_res.link_mode == MODE_SERVER))
        else $error("frame done without server mode");

    a_column_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_mode == MODE_RECV && !n_hdr && !res.line_done) |=>
            ({1'b0, r_col} < lb))
        else $error("column beyond line length");
`endif

endmodule

`default_nettype wire
